FILE: hdl/rsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_pkg: shared constants and types
// Widths, state codes and status codes of the rolling spread volatility unit.
// ----------------------------------------------------------------------------
package rsv_pkg;

  localparam int PRICE_BITS    = 32;
  localparam int NUM_PAIRS     = 8;
  localparam int PAIR_BITS     = 3;
  localparam int HISTORY_DEPTH = 256;
  localparam int DEPTH_BITS    = 8;
  localparam int ADDR_W        = PAIR_BITS + DEPTH_BITS;
  localparam int MEM_DEPTH     = NUM_PAIRS * HISTORY_DEPTH;

  localparam int WIN_W    = 9;           // window length / sample count
  localparam int SPREAD_W = 34;          // signed doubled spread
  localparam int MAG_W    = 33;          // spread magnitude
  localparam int SQR_W    = 2 * MAG_W;   // one squared spread
  localparam int SUM_W    = 42;          // signed sum of up to 256 spreads
  localparam int MS_W     = 41;          // magnitude of the sum
  localparam int SQ_W     = 74;          // sum of squares
  localparam int PROD_W   = 83;          // n*sumsq and sum^2
  localparam int FRAC_W   = 16;          // 65536 scale
  localparam int NUM_W    = PROD_W + FRAC_W;
  localparam int DEN_W    = 16;          // n*(n-1)
  localparam int ROOT_W   = 50;
  localparam int VOL_W    = 41;

  localparam logic [WIN_W-1:0] WIN_RESET = 9'd20;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_FEW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ACC,
    S_MUL1_GO,
    S_MUL1_WAIT,
    S_MUL2_GO,
    S_MUL2_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_DONE
  } state_t;

endpackage

FILE: hdl/rsv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_if: word channels
// Valid/ready channels for quote words in and result words out.
// ----------------------------------------------------------------------------
interface rsv_in_if;
  logic                             valid;
  logic                             ready;
  logic [rsv_pkg::PAIR_BITS-1:0]    pair_id;
  logic [31:0]                      bid_first;
  logic [31:0]                      ask_first;
  logic [31:0]                      bid_second;
  logic [31:0]                      ask_second;

  modport source(output valid, pair_id, bid_first, ask_first, bid_second, ask_second,
                 input ready);
  modport sink(input valid, pair_id, bid_first, ask_first, bid_second, ask_second,
               output ready);
endinterface

interface rsv_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rsv_pkg::SPREAD_W-1:0] spread_doubled;
  logic [rsv_pkg::VOL_W-1:0]        volatility;
  logic [1:0]                       status;

  modport source(output valid, spread_doubled, volatility, status, input ready);
  modport sink(input valid, spread_doubled, volatility, status, output ready);
endinterface

FILE: hdl/rolling_spread_volatility_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_spread_volatility_unit: per-pair rolling spread deviation
// Stores doubled mid-price spreads per pair and reports their sample
// standard deviation over the configured window.
// ----------------------------------------------------------------------------
// Usage:
//   in_word  : quote word (pair, two bids, two asks), valid/ready.
//   out_word : one result word per quote (spread, deviation, status).
//   cfg_wr_en/cfg_wr_data : window length, write only while idle.
// Timing: one quote at a time. A rejected quote or one with fewer than two
//   samples in the window goes from the check straight to its result.
//   Otherwise the unit walks the history RAM (one read port), then runs the
//   bit-serial multiplier (up to 9 steps for n*sum(x^2), up to 41 for sum^2),
//   the 99-step divider and the 50-step root. The next quote is taken
//   only once the unit is back in idle.
// Reset: fill counts and write positions of all pairs clear, window = 20.
//   The history RAM is not cleared; only written entries are ever read.
// Stall: the finished result sits in the output register; the next quote
//   is taken and worked on meanwhile, and only its own result waits for
//   the register to empty.
// ----------------------------------------------------------------------------
module rolling_spread_volatility_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  rsv_in_if.sink                       in_word,
  rsv_out_if.source                    out_word,
  input  logic                         cfg_wr_en,
  input  logic [rsv_pkg::WIN_W-1:0]    cfg_wr_data
);

  localparam int PB = rsv_pkg::PRICE_BITS;

  rsv_pkg::state_t state_r, state_nxt;

  // window register
  logic [rsv_pkg::WIN_W-1:0] window_r;

  // latched quote
  logic [rsv_pkg::PAIR_BITS-1:0] pair_r;
  logic [PB-1:0] bid_a_r, ask_a_r, bid_b_r, ask_b_r;

  // per-pair bookkeeping
  logic [rsv_pkg::WIN_W-1:0]      fill_r [rsv_pkg::NUM_PAIRS];
  logic [rsv_pkg::DEPTH_BITS-1:0] wpos_r [rsv_pkg::NUM_PAIRS];

  // history RAM
  logic [rsv_pkg::SPREAD_W-1:0] hist_mem [rsv_pkg::MEM_DEPTH];
  logic [rsv_pkg::SPREAD_W-1:0] rd_data_r;
  logic [rsv_pkg::ADDR_W-1:0]   rd_addr;
  logic [rsv_pkg::ADDR_W-1:0]   wr_addr;
  logic                         wr_en;

  // walk / accumulate
  logic [rsv_pkg::DEPTH_BITS-1:0] pos_r;
  logic [rsv_pkg::WIN_W-1:0]      n_r;
  logic [rsv_pkg::WIN_W-1:0]      iss_cnt_r;
  logic [rsv_pkg::WIN_W-1:0]      acc_cnt_r;
  logic                           iss_en;
  logic                           rd_vld_r;
  logic                           sq_vld_r;
  logic [rsv_pkg::SPREAD_W-1:0]   v_r;
  logic [rsv_pkg::SQR_W-1:0]      sqr_r;
  logic signed [rsv_pkg::SUM_W-1:0] sum_r;
  logic [rsv_pkg::SQ_W-1:0]       sq_r;
  logic [rsv_pkg::SPREAD_W-1:0]   rd_mag;
  logic [rsv_pkg::MS_W-1:0]       sum_mag;
  logic [rsv_pkg::DEN_W-1:0]      den_r;

  // quote check
  logic                           bad;
  logic [rsv_pkg::SPREAD_W-1:0]   spread;
  logic [rsv_pkg::WIN_W-1:0]      fill_new;
  logic [rsv_pkg::WIN_W-1:0]      n_new;

  // arithmetic units
  logic                           mul_start, mul_done;
  logic [rsv_pkg::SQ_W-1:0]       mul_a;
  logic [rsv_pkg::MS_W-1:0]       mul_b;
  logic [rsv_pkg::PROD_W-1:0]     mul_p;
  logic [rsv_pkg::PROD_W-1:0]     nsq_r;
  logic [rsv_pkg::NUM_W-1:0]      num_r;
  logic                           div_start, div_done;
  logic [rsv_pkg::NUM_W-1:0]      quot;
  logic                           sqrt_start, sqrt_done;
  logic [rsv_pkg::ROOT_W-1:0]     root;

  // result
  logic [rsv_pkg::SPREAD_W-1:0]   res_spread_r;
  logic [rsv_pkg::VOL_W-1:0]      res_vol_r;
  rsv_pkg::status_t               res_status_r;
  logic                           out_valid_r;
  logic                           out_load;
  logic [rsv_pkg::SPREAD_W-1:0]   out_spread_r;
  logic [rsv_pkg::VOL_W-1:0]      out_vol_r;
  rsv_pkg::status_t               out_status_r;

  // ---------------------------------------------------------------- check
  assign bad = ({1'b0, pair_r} >= (rsv_pkg::PAIR_BITS+1)'(rsv_pkg::NUM_PAIRS)) ||
               (bid_a_r == '0) || (ask_a_r == '0) || (ask_a_r < bid_a_r) ||
               (bid_b_r == '0) || (ask_b_r == '0) || (ask_b_r < bid_b_r);

  // (bidA+askA)-(bidB+askB), 34-bit two's complement
  assign spread = rsv_pkg::SPREAD_W'({1'b0, bid_a_r} + {1'b0, ask_a_r}) -
                  rsv_pkg::SPREAD_W'({1'b0, bid_b_r} + {1'b0, ask_b_r});

  assign fill_new = (fill_r[pair_r] < rsv_pkg::WIN_W'(rsv_pkg::HISTORY_DEPTH)) ?
                    fill_r[pair_r] + 1'b1 : fill_r[pair_r];
  assign n_new    = (window_r < fill_new) ? window_r : fill_new;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsv_pkg::S_IDLE: begin
        if (in_word.valid) state_nxt = rsv_pkg::S_CHECK;
      end
      rsv_pkg::S_CHECK: begin
        if (bad || (n_new < rsv_pkg::WIN_W'(2))) state_nxt = rsv_pkg::S_DONE;
        else state_nxt = rsv_pkg::S_ACC;
      end
      rsv_pkg::S_ACC: begin
        if (acc_cnt_r == n_r) state_nxt = rsv_pkg::S_MUL1_GO;
      end
      rsv_pkg::S_MUL1_GO:   state_nxt = rsv_pkg::S_MUL1_WAIT;
      rsv_pkg::S_MUL1_WAIT: begin
        if (mul_done) state_nxt = rsv_pkg::S_MUL2_GO;
      end
      rsv_pkg::S_MUL2_GO:   state_nxt = rsv_pkg::S_MUL2_WAIT;
      rsv_pkg::S_MUL2_WAIT: begin
        if (mul_done) state_nxt = rsv_pkg::S_DIV_GO;
      end
      rsv_pkg::S_DIV_GO:    state_nxt = rsv_pkg::S_DIV_WAIT;
      rsv_pkg::S_DIV_WAIT: begin
        if (div_done) state_nxt = rsv_pkg::S_SQRT_GO;
      end
      rsv_pkg::S_SQRT_GO:   state_nxt = rsv_pkg::S_SQRT_WAIT;
      rsv_pkg::S_SQRT_WAIT: begin
        if (sqrt_done) state_nxt = rsv_pkg::S_DONE;
      end
      rsv_pkg::S_DONE: begin
        if (!out_valid_r || out_word.ready) state_nxt = rsv_pkg::S_IDLE;
      end
      default: state_nxt = rsv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_word.ready = (state_r == rsv_pkg::S_IDLE);
    wr_en         = (state_r == rsv_pkg::S_CHECK) && !bad;
    iss_en        = (state_r == rsv_pkg::S_ACC) && (iss_cnt_r < n_r);
    mul_start     = (state_r == rsv_pkg::S_MUL1_GO) || (state_r == rsv_pkg::S_MUL2_GO);
    div_start     = (state_r == rsv_pkg::S_DIV_GO);
    sqrt_start    = (state_r == rsv_pkg::S_SQRT_GO);
    out_load      = (state_r == rsv_pkg::S_DONE) && (!out_valid_r || out_word.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rsv_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) window_r <= rsv_pkg::WIN_RESET;
    else if (cfg_wr_en) window_r <= cfg_wr_data;
  end

  // ---------------------------------------------------------------- input latch
  always_ff @(posedge clk) begin
    if (in_word.valid && in_word.ready) begin
      pair_r  <= in_word.pair_id;
      bid_a_r <= in_word.bid_first[PB-1:0];
      ask_a_r <= in_word.ask_first[PB-1:0];
      bid_b_r <= in_word.bid_second[PB-1:0];
      ask_b_r <= in_word.ask_second[PB-1:0];
    end
  end

  // ---------------------------------------------------------------- pair state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rsv_pkg::NUM_PAIRS; i++) begin
        fill_r[i] <= '0;
        wpos_r[i] <= '0;
      end
    end else if (wr_en) begin
      fill_r[pair_r] <= fill_new;
      wpos_r[pair_r] <= wpos_r[pair_r] + 1'b1;  // ring wraps at depth
    end
  end

  // ---------------------------------------------------------------- history RAM
  assign wr_addr = {pair_r, wpos_r[pair_r]};
  assign rd_addr = {pair_r, pos_r - iss_cnt_r[rsv_pkg::DEPTH_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[wr_addr] <= spread;
    if (iss_en) rd_data_r <= hist_mem[rd_addr];
  end

  // ---------------------------------------------------------------- walk
  assign rd_mag  = rd_data_r[rsv_pkg::SPREAD_W-1] ? (~rd_data_r + 1'b1) : rd_data_r;
  assign sum_mag = sum_r[rsv_pkg::SUM_W-1] ? rsv_pkg::MS_W'(-sum_r)
                                           : sum_r[rsv_pkg::MS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= iss_en;
      sq_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rsv_pkg::S_CHECK) begin
      pos_r     <= wpos_r[pair_r];
      n_r       <= n_new;
      iss_cnt_r <= '0;
      acc_cnt_r <= '0;
      sum_r     <= '0;
      sq_r      <= '0;
    end else begin
      if (iss_en) iss_cnt_r <= iss_cnt_r + 1'b1;
      if (sq_vld_r) begin
        sum_r     <= sum_r + {{(rsv_pkg::SUM_W-rsv_pkg::SPREAD_W){v_r[rsv_pkg::SPREAD_W-1]}},
                              v_r};
        sq_r      <= sq_r + {{(rsv_pkg::SQ_W-rsv_pkg::SQR_W){1'b0}}, sqr_r};
        acc_cnt_r <= acc_cnt_r + 1'b1;
      end
    end
    if (rd_vld_r) begin
      v_r   <= rd_data_r;
      sqr_r <= rd_mag[rsv_pkg::MAG_W-1:0] * rd_mag[rsv_pkg::MAG_W-1:0];
    end
    den_r <= rsv_pkg::DEN_W'(n_r) * rsv_pkg::DEN_W'(n_r - 1'b1);
  end

  // ---------------------------------------------------------------- variance
  always_comb begin
    if (state_r == rsv_pkg::S_MUL1_GO) begin
      mul_a = sq_r;
      mul_b = {{(rsv_pkg::MS_W-rsv_pkg::WIN_W){1'b0}}, n_r};
    end else begin
      mul_a = {{(rsv_pkg::SQ_W-rsv_pkg::MS_W){1'b0}}, sum_mag};
      mul_b = sum_mag;
    end
  end

  rsv_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if ((state_r == rsv_pkg::S_MUL1_WAIT) && mul_done) nsq_r <= mul_p;
    if ((state_r == rsv_pkg::S_MUL2_WAIT) && mul_done) begin
      num_r <= {nsq_r - mul_p, {rsv_pkg::FRAC_W{1'b0}}};  // times 65536
    end
  end

  rsv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  rsv_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (quot),
    .done  (sqrt_done),
    .root  (root)
  );

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (state_r == rsv_pkg::S_CHECK) begin
      res_vol_r <= '0;
      if (bad) begin
        res_spread_r <= '0;
        res_status_r <= rsv_pkg::ST_BAD;
      end else begin
        res_spread_r <= spread;
        res_status_r <= (n_new < rsv_pkg::WIN_W'(2)) ? rsv_pkg::ST_FEW : rsv_pkg::ST_OK;
      end
    end else if ((state_r == rsv_pkg::S_SQRT_WAIT) && sqrt_done) begin
      // saturate to the 41-bit field
      res_vol_r <= (root[rsv_pkg::ROOT_W-1:rsv_pkg::VOL_W] != '0) ? {rsv_pkg::VOL_W{1'b1}}
                                                                 : root[rsv_pkg::VOL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_spread_r <= res_spread_r;
      out_vol_r    <= res_vol_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_word.valid          = out_valid_r;
  assign out_word.spread_doubled = out_spread_r;
  assign out_word.volatility     = out_vol_r;
  assign out_word.status         = out_status_r;

endmodule

FILE: hdl/rsv_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_mul: shift-add multiplier
// One multiplier bit per cycle, stops early when the remaining bits are zero.
// ----------------------------------------------------------------------------
module rsv_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rsv_pkg::SQ_W-1:0]     a,
  input  logic [rsv_pkg::MS_W-1:0]     b,
  output logic                         done,
  output logic [rsv_pkg::PROD_W-1:0]   product
);

  logic [rsv_pkg::PROD_W-1:0] a_r;
  logic [rsv_pkg::MS_W-1:0]   b_r;
  logic [rsv_pkg::PROD_W-1:0] acc_r;
  logic                       busy_r;
  logic                       done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= {{(rsv_pkg::PROD_W-rsv_pkg::SQ_W){1'b0}}, a};
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

FILE: hdl/rsv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_div: restoring divider
// One quotient bit per cycle, numerator shifted in MSB first.
// ----------------------------------------------------------------------------
module rsv_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rsv_pkg::NUM_W-1:0]    num,
  input  logic [rsv_pkg::DEN_W-1:0]    den,
  output logic                         done,
  output logic [rsv_pkg::NUM_W-1:0]    quot
);

  localparam int CNT_W = $clog2(rsv_pkg::NUM_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(rsv_pkg::NUM_W);

  logic [rsv_pkg::NUM_W-1:0] q_r;
  logic [rsv_pkg::DEN_W-1:0] den_r;
  logic [rsv_pkg::DEN_W-1:0] rem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      done_r;
  logic [rsv_pkg::DEN_W:0]   rem_t;
  logic                      fit;

  assign rem_t = {rem_r, q_r[rsv_pkg::NUM_W-1]};
  assign fit   = rem_t >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= STEPS;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fit ? rsv_pkg::DEN_W'(rem_t - {1'b0, den_r}) : rem_t[rsv_pkg::DEN_W-1:0];
      q_r   <= {q_r[rsv_pkg::NUM_W-2:0], fit};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: hdl/rsv_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_sqrt: digit-by-digit integer square root
// One root bit per cycle, two radicand bits consumed per step.
// ----------------------------------------------------------------------------
module rsv_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rsv_pkg::NUM_W-1:0]    rad,
  output logic                         done,
  output logic [rsv_pkg::ROOT_W-1:0]   root
);

  localparam int RAD_W = 2 * rsv_pkg::ROOT_W;
  localparam int REM_W = rsv_pkg::ROOT_W + 1;
  localparam int CNT_W = $clog2(rsv_pkg::ROOT_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(rsv_pkg::ROOT_W);

  logic [RAD_W-1:0]          rad_r;
  logic [REM_W-1:0]          rem_r;
  logic [rsv_pkg::ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      done_r;
  logic [REM_W+1:0]          rem_t;
  logic [REM_W+1:0]          trial;
  logic                      fit;

  assign rem_t = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fit   = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= STEPS;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {{(RAD_W-rsv_pkg::NUM_W){1'b0}}, rad};
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= fit ? REM_W'(rem_t - trial) : rem_t[REM_W-1:0];
      root_r <= {root_r[rsv_pkg::ROOT_W-2:0], fit};
      rad_r  <= rad_r << 2;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
